@@ rtl/format_specifier_checker_assert.svh @@
// ----------------------------------------------------------------------------
// format_specifier_checker assertion macros
// Shared concurrent assertion shorthands, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef FORMAT_SPECIFIER_CHECKER_ASSERT_SVH
`define FORMAT_SPECIFIER_CHECKER_ASSERT_SVH

// same-cycle implication
`define FSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg
// Types, codes and character classes of the format string checker.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int CharW = 8;
  localparam int ConvW = 2;
  localparam int ModW  = 6;
  localparam int PhaseW = 4;

  localparam logic [ConvW-1:0] MaxConv  = 2'd3;
  localparam logic [ConvW-1:0] NoString = 2'd3;

  // parser phases
  localparam logic [PhaseW-1:0] PhText   = 4'd0;
  localparam logic [PhaseW-1:0] PhPct    = 4'd1;
  localparam logic [PhaseW-1:0] PhL1     = 4'd2;
  localparam logic [PhaseW-1:0] PhL2     = 4'd3;
  localparam logic [PhaseW-1:0] PhP      = 4'd4;
  localparam logic [PhaseW-1:0] PhPk     = 4'd5;
  localparam logic [PhaseW-1:0] PhFollow = 4'd6;

  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChPct   = 8'h25;
  localparam logic [CharW-1:0] ChLowL  = 8'h6C;
  localparam logic [CharW-1:0] ChLowP  = 8'h70;
  localparam logic [CharW-1:0] ChLowS  = 8'h73;
  localparam logic [CharW-1:0] ChLowK  = 8'h6B;
  localparam logic [CharW-1:0] ChLowU  = 8'h75;
  localparam logic [CharW-1:0] ChUpB   = 8'h42;
  localparam logic [CharW-1:0] ChLowI  = 8'h69;
  localparam logic [CharW-1:0] ChLowD  = 8'h64;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [ConvW-1:0] arg_count;
    logic [1:0]       size_mod_first;
    logic [1:0]       size_mod_second;
    logic [1:0]       size_mod_third;
    logic [ConvW-1:0] string_arg;
  } result_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic is_print(input logic [CharW-1:0] c);
    return c inside {[8'h20:8'h7E]};
  endfunction

  function automatic logic is_punct(input logic [CharW-1:0] c);
    logic alnum;
    alnum = (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h5A]}) ||
            (c inside {[8'h61:8'h7A]});
    return (c inside {[8'h21:8'h7E]}) && !alnum;
  endfunction

  function automatic logic is_int_conv(input logic [CharW-1:0] c);
    return (c == ChLowD) || (c == ChLowI) || (c == ChLowU) || (c == ChLowX);
  endfunction

endpackage

@@ rtl/fsc_in_if.sv @@
// ----------------------------------------------------------------------------
// fsc_in_if
// Character channel: one format string byte per beat.
// ----------------------------------------------------------------------------
interface fsc_in_if;
  import fsc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             is_last;

  modport source (output valid, output character, output is_last, input ready);
  modport sink   (input valid, input character, input is_last, output ready);
endinterface

@@ rtl/fsc_out_if.sv @@
// ----------------------------------------------------------------------------
// fsc_out_if
// Verdict channel: one beat per completed format string.
// ----------------------------------------------------------------------------
interface fsc_out_if;
  import fsc_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [ConvW-1:0] arg_count;
  logic [1:0]       size_mod_first;
  logic [1:0]       size_mod_second;
  logic [1:0]       size_mod_third;
  logic [ConvW-1:0] string_arg;

  modport source (output valid, output status, output arg_count, output size_mod_first,
                  output size_mod_second, output size_mod_third, output string_arg,
                  input ready);
  modport sink   (input valid, input status, input arg_count, input size_mod_first,
                  input size_mod_second, input size_mod_third, input string_arg,
                  output ready);
endinterface

@@ rtl/fsc_in_stage.sv @@
// ----------------------------------------------------------------------------
// fsc_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module fsc_in_stage
  import fsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  out_free,
  output logic  item_fire,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // a last byte needs room in the result register; other bytes always advance
  assign item_fire = valid_r && (!item_r.is_last || out_free);
  assign in_ready  = !valid_r || item_fire;
  assign item      = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/fsc_parser.sv @@
// ----------------------------------------------------------------------------
// fsc_parser
// Format string parser state and its per-byte update.
// ----------------------------------------------------------------------------
module fsc_parser
  import fsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_fire,
  input  item_t   item,
  output result_t result
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [ConvW-1:0]  conv_r, conv_nxt;
  logic [ModW-1:0]   mods_r, mods_nxt;
  logic              str_seen_r, str_seen_nxt;
  logic [ConvW-1:0]  str_idx_r, str_idx_nxt;
  logic              rej_r, rej_nxt;

  logic [CharW-1:0]  ch;
  logic [ConvW-1:0]  conv_inc;
  logic [2:0]        slot_sh;
  logic [1:0]        slot_cur;
  logic [ModW-1:0]   mods_bump;
  logic              do_text;
  logic              do_follow;
  logic              do_string;
  logic              do_int;
  logic [ConvW-1:0]  text_conv;
  logic              ok_end;

  assign ch       = item.character;
  assign conv_inc = (conv_r == MaxConv) ? conv_r : conv_r + 2'd1;
  assign slot_sh  = {conv_r, 1'b0};
  assign slot_cur = 2'(mods_r >> slot_sh);
  assign mods_bump = ((conv_r != MaxConv) && (slot_cur != 2'd3)) ?
                     mods_r + (ModW'(1) << slot_sh) : mods_r;

  always_comb begin
    phase_nxt    = phase_r;
    conv_nxt     = conv_r;
    mods_nxt     = mods_r;
    str_seen_nxt = str_seen_r;
    str_idx_nxt  = str_idx_r;
    rej_nxt      = rej_r;
    do_text      = 1'b0;
    do_follow    = 1'b0;
    do_string    = 1'b0;
    do_int       = 1'b0;
    text_conv    = conv_r;
    ok_end       = 1'b0;

    if (!rej_r) begin
      if (item.is_last) begin
        ok_end = (phase_r == PhText) || (phase_r == PhP) || (phase_r == PhFollow);
        if (phase_r == PhP) begin
          conv_nxt = conv_inc;
        end
        if ((ch != ChNul) || !ok_end) begin
          rej_nxt = 1'b1;
        end
      end else begin
        case (phase_r)
          PhText: begin
            do_text = 1'b1;
          end
          PhPct: begin
            if (ch == ChLowL) begin
              mods_nxt  = mods_bump;
              phase_nxt = PhL1;
            end else if (ch == ChLowP) begin
              mods_nxt  = mods_bump;
              phase_nxt = PhP;
            end else if (ch == ChLowS) begin
              mods_nxt  = mods_bump;
              do_string = 1'b1;
            end else begin
              do_int = 1'b1;
            end
          end
          PhL1: begin
            if (ch == ChLowL) begin
              mods_nxt  = mods_bump;
              phase_nxt = PhL2;
            end else begin
              do_int = 1'b1;
            end
          end
          PhL2: begin
            do_int = 1'b1;
          end
          PhP: begin
            if ((ch == ChLowK) || (ch == ChLowU)) begin
              phase_nxt = PhPk;
            end else if (ch == ChUpB) begin
              conv_nxt  = conv_inc;
              phase_nxt = PhText;
            end else begin
              // plain %p closes here; the byte is then checked as a follower
              conv_nxt  = conv_inc;
              text_conv = conv_inc;
              do_follow = 1'b1;
            end
          end
          PhPk: begin
            if (ch == ChLowS) begin
              do_string = 1'b1;
            end else begin
              rej_nxt = 1'b1;
            end
          end
          PhFollow: begin
            do_follow = 1'b1;
          end
          default: begin
            rej_nxt = 1'b1;
          end
        endcase

        if (do_int) begin
          if (is_int_conv(ch)) begin
            conv_nxt  = conv_inc;
            phase_nxt = PhText;
          end else begin
            rej_nxt = 1'b1;
          end
        end

        if (do_string) begin
          if (str_seen_r) begin
            rej_nxt = 1'b1;
          end else begin
            str_seen_nxt = 1'b1;
            str_idx_nxt  = conv_r;
            conv_nxt     = conv_inc;
            phase_nxt    = PhFollow;
          end
        end

        if (do_follow) begin
          if ((ch != ChNul) && !is_space(ch) && !is_punct(ch)) begin
            rej_nxt = 1'b1;
          end else begin
            do_text = 1'b1;
          end
        end

        if (do_text) begin
          if (!is_print(ch) && !is_space(ch)) begin
            rej_nxt = 1'b1;
          end else if (ch != ChPct) begin
            phase_nxt = PhText;
          end else if (text_conv == MaxConv) begin
            rej_nxt = 1'b1;
          end else begin
            phase_nxt = PhPct;
          end
        end
      end
    end
  end

  // verdict for the byte being consumed; used only on the last byte
  always_comb begin
    if (rej_nxt) begin
      result = '{status: 1'b1, arg_count: '0, size_mod_first: '0,
                 size_mod_second: '0, size_mod_third: '0, string_arg: NoString};
    end else begin
      result = '{status: 1'b0, arg_count: conv_nxt, size_mod_first: mods_nxt[1:0],
                 size_mod_second: mods_nxt[3:2], size_mod_third: mods_nxt[5:4],
                 string_arg: str_idx_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PhText;
      conv_r     <= '0;
      mods_r     <= '0;
      str_seen_r <= 1'b0;
      str_idx_r  <= NoString;
      rej_r      <= 1'b0;
    end else if (item_fire) begin
      if (item.is_last) begin
        // string done: start over for the next one
        phase_r    <= PhText;
        conv_r     <= '0;
        mods_r     <= '0;
        str_seen_r <= 1'b0;
        str_idx_r  <= NoString;
        rej_r      <= 1'b0;
      end else begin
        phase_r    <= phase_nxt;
        conv_r     <= conv_nxt;
        mods_r     <= mods_nxt;
        str_seen_r <= str_seen_nxt;
        str_idx_r  <= str_idx_nxt;
        rej_r      <= rej_nxt;
      end
    end
  end

endmodule

@@ rtl/fsc_out_stage.sv @@
// ----------------------------------------------------------------------------
// fsc_out_stage
// Result register: holds a verdict beat until the receiver takes it.
// ----------------------------------------------------------------------------
module fsc_out_stage
  import fsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result_in,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result_out
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign result_out = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result_in;
    end
  end

endmodule

@@ rtl/format_specifier_checker.sv @@
// ----------------------------------------------------------------------------
// format_specifier_checker
// Checks a restricted printf format string, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the format string one byte per beat; is_last marks the
//   terminating byte, which must be zero. out_ch carries one verdict beat per
//   string: status, conversion count, the three length modifiers and the
//   index of the string conversion (3 when there is none).
//   Throughput: one byte per cycle, including across strings, if out_ch keeps up.
//   After the last byte is accepted it sits in the input register, then its
//   verdict loads the result register and out_ch valid rises; the receiver
//   takes it when out_ch ready is high.
//   The parser state is updated by a single pass of logic per byte.
//   When out_ch stalls, non-final bytes keep flowing; a final byte waits in
//   the input register until the result register frees, and in_ch ready
//   drops only then.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to plain text with no conversions seen.
// ----------------------------------------------------------------------------
module format_specifier_checker
  import fsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fsc_in_if.sink    in_ch,
  fsc_out_if.source out_ch
);

  item_t   in_item;
  item_t   item;
  logic    item_fire;
  logic    out_free;
  result_t result;
  result_t result_q;

  assign in_item = '{character: in_ch.character, is_last: in_ch.is_last};

  fsc_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_item),
    .out_free  (out_free),
    .item_fire (item_fire),
    .item      (item)
  );

  fsc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (item_fire),
    .item      (item),
    .result    (result)
  );

  fsc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (item_fire && item.is_last),
    .result_in  (result),
    .out_free   (out_free),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .result_out (result_q)
  );

  assign out_ch.status          = result_q.status;
  assign out_ch.arg_count       = result_q.arg_count;
  assign out_ch.size_mod_first  = result_q.size_mod_first;
  assign out_ch.size_mod_second = result_q.size_mod_second;
  assign out_ch.size_mod_third  = result_q.size_mod_third;
  assign out_ch.string_arg      = result_q.string_arg;

endmodule

@@ rtl/fsc_checker.sv @@
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the format string checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "format_specifier_checker_assert.svh"

module fsc_checker
  import fsc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_is_last,
  input logic             out_valid,
  input logic             out_ready,
  input logic             status,
  input logic [ConvW-1:0] arg_count,
  input logic [1:0]       size_mod_first,
  input logic [1:0]       size_mod_second,
  input logic [1:0]       size_mod_third,
  input logic [ConvW-1:0] string_arg
);

  logic                         out_stall;
  logic [ConvW+ModW+ConvW:0]    verdict;
  logic                         reject_clean;
  logic                         string_beat;
  logic                         in_last_fire;

  assign out_stall    = out_valid && !out_ready;
  assign verdict      = {status, arg_count, size_mod_first, size_mod_second,
                         size_mod_third, string_arg};
  assign reject_clean = ({arg_count, size_mod_first, size_mod_second, size_mod_third} == '0) &&
                        (string_arg == NoString);
  assign string_beat  = out_valid && !status && (string_arg != NoString);
  assign in_last_fire = in_valid && in_ready && in_is_last;

  // a stalled verdict beat holds
  `FSC_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(verdict), "stalled verdict changed")

  // a rejected string reports nothing else
  `FSC_ASSERT_SAME(a_reject_clean, out_valid && status, reject_clean, "rejected verdict carries data")

  // the string conversion is one of the conversions counted
  `FSC_ASSERT_SAME(a_string_in_range, string_beat, string_arg < arg_count, "string index beyond count")

  // a new verdict follows an accepted last byte
  `FSC_ASSERT_SAME(a_verdict_source, $rose(out_valid), $past(in_last_fire, 2), "verdict without a final byte")

endmodule

bind format_specifier_checker fsc_checker u_fsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_is_last      (in_ch.is_last),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .arg_count       (out_ch.arg_count),
  .size_mod_first  (out_ch.size_mod_first),
  .size_mod_second (out_ch.size_mod_second),
  .size_mod_third  (out_ch.size_mod_third),
  .string_arg      (out_ch.string_arg)
);

@@ test/fsc_verdict_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_verdict_checker
// Watches both channels of the format string checker. Every accepted byte
// runs through a local parser model. A final byte queues the verdict that
// the parser predicts. Every verdict beat is compared, field by field, with
// the oldest queued verdict.
// ----------------------------------------------------------------------------
module fsc_verdict_checker
  import fsc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fsc_in_if    in_ch,
  fsc_out_if   out_ch,
  output int   mismatches,
  output int   pending,
  output int   rejected_seen
);

  logic [PhaseW-1:0] phase;
  logic [ConvW-1:0]  conv_count;
  logic [ModW-1:0]   mod_bits;
  logic              have_string;
  logic [ConvW-1:0]  string_slot;
  logic              spoiled;
  result_t           expected_verdicts[$];

  function automatic logic is_blank(logic [CharW-1:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_printable(logic [CharW-1:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  function automatic logic is_mark(logic [CharW-1:0] c);
    logic alnum;
    alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    return c > 8'h20 && c <= 8'h7E && !alnum;
  endfunction

  function void clear_parse();
    phase       = PhText;
    conv_count  = '0;
    mod_bits    = '0;
    have_string = 1'b0;
    string_slot = NoString;
    spoiled     = 1'b0;
  endfunction

  function void bump_mod();
    logic [1:0] cur;
    if (conv_count < MaxConv) begin
      cur = mod_bits[2*conv_count +: 2];
      if (cur != 2'd3) mod_bits[2*conv_count +: 2] = cur + 2'd1;
    end
  endfunction

  function void close_conv();
    if (conv_count < MaxConv) conv_count = conv_count + 2'd1;
  endfunction

  function void open_string();
    if (have_string) begin
      spoiled = 1'b1;
    end else begin
      have_string = 1'b1;
      string_slot = conv_count;
      close_conv();
      phase = PhFollow;
    end
  endfunction

  function void text_byte(logic [CharW-1:0] c);
    if (!is_printable(c) && !is_blank(c)) spoiled = 1'b1;
    else if (c != ChPct) phase = PhText;
    else if (conv_count >= MaxConv) spoiled = 1'b1;
    else phase = PhPct;
  endfunction

  // the byte after %p or a string conversion must be a separator, then counts as text
  function void after_token(logic [CharW-1:0] c);
    if (c != ChNul && !is_blank(c) && !is_mark(c)) spoiled = 1'b1;
    else text_byte(c);
  endfunction

  function void int_or_spoil(logic [CharW-1:0] c);
    if (c == ChLowD || c == ChLowI || c == ChLowU || c == ChLowX) begin
      close_conv();
      phase = PhText;
    end else begin
      spoiled = 1'b1;
    end
  endfunction

  function void take_byte(logic [CharW-1:0] c, logic last);
    logic fits;
    if (spoiled) return;
    if (last) begin
      fits = (phase == PhText) || (phase == PhP) || (phase == PhFollow);
      if (phase == PhP) close_conv();
      if (c != ChNul || !fits) spoiled = 1'b1;
      return;
    end
    case (phase)
      PhText: text_byte(c);
      PhPct: begin
        if (c == ChLowL) begin
          bump_mod();
          phase = PhL1;
        end else if (c == ChLowP) begin
          bump_mod();
          phase = PhP;
        end else if (c == ChLowS) begin
          bump_mod();
          open_string();
        end else begin
          int_or_spoil(c);
        end
      end
      PhL1: begin
        if (c == ChLowL) begin
          bump_mod();
          phase = PhL2;
        end else begin
          int_or_spoil(c);
        end
      end
      PhL2: int_or_spoil(c);
      PhP: begin
        if (c == ChLowK || c == ChLowU) begin
          phase = PhPk;
        end else if (c == ChUpB) begin
          close_conv();
          phase = PhText;
        end else begin
          close_conv();
          after_token(c);
        end
      end
      PhPk: begin
        if (c == ChLowS) open_string();
        else spoiled = 1'b1;
      end
      PhFollow: after_token(c);
      default: spoiled = 1'b1;
    endcase
  endfunction

  task automatic check_field(string name, int want, int seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parse();
      expected_verdicts.delete();
      mismatches    = 0;
      rejected_seen = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_byte(in_ch.character, in_ch.is_last);
        if (in_ch.is_last) begin
          if (spoiled) begin
            want = '{status: 1'b1, arg_count: '0, size_mod_first: '0,
                     size_mod_second: '0, size_mod_third: '0, string_arg: NoString};
          end else begin
            want = '{status: 1'b0, arg_count: conv_count, size_mod_first: mod_bits[1:0],
                     size_mod_second: mod_bits[3:2], size_mod_third: mod_bits[5:4],
                     string_arg: string_slot};
          end
          expected_verdicts.push_back(want);
          clear_parse();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (out_ch.status) rejected_seen++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict beat with none expected, status actual %0d", $time,
                   out_ch.status);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("status", want.status, out_ch.status);
          check_field("arg_count", want.arg_count, out_ch.arg_count);
          check_field("size_mod_first", want.size_mod_first, out_ch.size_mod_first);
          check_field("size_mod_second", want.size_mod_second, out_ch.size_mod_second);
          check_field("size_mod_third", want.size_mod_third, out_ch.size_mod_third);
          check_field("string_arg", want.string_arg, out_ch.string_arg);
        end
      end
    end
    pending = expected_verdicts.size();
  end

endmodule

@@ test/tb_format_specifier_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_format_specifier_checker
// Feeds format strings byte by byte into the checker: a directed set of
// corner cases first, then random strings, mostly well formed with random
// content, some broken or noisy. Both channels idle at random; the verdict
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_format_specifier_checker;
  import fsc_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int MaxWait     = 13;
  localparam int RandomBytes = 1450;
  localparam int DrainCycles = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;
  int   cycles = 0;
  int   strings_sent = 0;
  int   bytes_sent = 0;
  int   mismatches;
  int   pending;
  int   rejected_seen;
  logic [CharW-1:0] fmt_q[$];

  fsc_in_if  in_ch ();
  fsc_out_if out_ch ();

  format_specifier_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fsc_verdict_checker verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .rejected_seen (rejected_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  // result side: stall a random number of cycles before taking each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_byte(logic [CharW-1:0] c, logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= c;
    in_ch.is_last   <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic play_format();
    foreach (fmt_q[i]) begin
      send_byte(fmt_q[i], i == fmt_q.size() - 1);
      bytes_sent++;
    end
    strings_sent++;
    fmt_q.delete();
  endtask

  task automatic run_text(string s, logic [CharW-1:0] tail);
    for (int i = 0; i < s.len(); i++) fmt_q.push_back(s[i]);
    fmt_q.push_back(tail);
    play_format();
  endtask

  function automatic void push_separator();
    string marks;
    marks = ".,;:!?)-]/";
    case ($urandom_range(0, 5))
      0: fmt_q.push_back(8'h20);
      1: fmt_q.push_back(8'($urandom_range(9, 13)));
      2, 3: fmt_q.push_back(marks[$urandom_range(0, marks.len() - 1)]);
      4: ;
      default: fmt_q.push_back(8'($urandom_range(97, 122)));
    endcase
  endfunction

  function automatic void push_text_run();
    logic [CharW-1:0] c;
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(9, 13));
      else c = 8'($urandom_range(32, 126));
      if (c == ChPct) c = 8'h20;
      fmt_q.push_back(c);
    end
  endfunction

  function automatic void push_conversion();
    int kind;
    kind = $urandom_range(0, 9);
    fmt_q.push_back(ChPct);
    if (kind <= 4) begin
      repeat ($urandom_range(0, 2)) fmt_q.push_back(ChLowL);
      case ($urandom_range(0, 3))
        0: fmt_q.push_back(ChLowD);
        1: fmt_q.push_back(ChLowI);
        2: fmt_q.push_back(ChLowU);
        default: fmt_q.push_back(ChLowX);
      endcase
      return;
    end
    case (kind)
      5: fmt_q.push_back(ChLowP);
      6: begin
        fmt_q.push_back(ChLowP);
        fmt_q.push_back(ChUpB);
        return;
      end
      7: begin
        fmt_q.push_back(ChLowP);
        fmt_q.push_back(ChLowK);
        fmt_q.push_back(ChLowS);
      end
      8: begin
        fmt_q.push_back(ChLowP);
        fmt_q.push_back(ChLowU);
        fmt_q.push_back(ChLowS);
      end
      default: fmt_q.push_back(ChLowS);
    endcase
    if ($urandom_range(0, 3) != 0) push_separator();
  endfunction

  function automatic void build_random_format();
    if ($urandom_range(0, 9) < 8) begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 1) == 0) push_text_run();
        else push_conversion();
      end
      // corrupt one byte now and then
      if (fmt_q.size() > 0 && $urandom_range(0, 11) == 0)
        fmt_q[$urandom_range(0, fmt_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 3))
          0: fmt_q.push_back(8'($urandom_range(0, 255)));
          1: fmt_q.push_back(ChPct);
          2: fmt_q.push_back($urandom_range(0, 1) ? ChLowL : ChLowP);
          default: fmt_q.push_back(8'($urandom_range(32, 126)));
        endcase
      end
    end
    if ($urandom_range(0, 11) == 0) fmt_q.push_back(8'($urandom_range(1, 255)));
    else fmt_q.push_back(ChNul);
  endfunction

  initial begin
    int start;
    in_ch.valid     = 1'b0;
    in_ch.character = '0;
    in_ch.is_last   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corner cases
    run_text("", ChNul);
    run_text("hi %d!", ChNul);
    run_text("%ld %lli %llx", ChNul);
    run_text("%p", ChNul);
    run_text("%pB%s", ChNul);
    run_text("%pks.", ChNul);
    run_text("%pus", ChNul);
    run_text("%p%d", ChNul);
    run_text("%d%d%s", ChNul);
    run_text("%s %s", ChNul);
    run_text("%d%d%d%d", ChNul);
    run_text("%%", ChNul);
    run_text("%q", ChNul);
    run_text("%lll", ChNul);
    run_text("%lp", ChNul);
    run_text("%pk", ChNul);
    run_text("%pkx", ChNul);
    run_text("%pa", ChNul);
    run_text("%sX", ChNul);
    run_text("%l", ChNul);
    run_text("abc", 8'h7A);
    run_text("", 8'hFF);
    fmt_q = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h7E, ChNul};
    play_format();
    fmt_q = '{8'h61, 8'h7F, ChNul};
    play_format();
    fmt_q = '{8'h80, 8'hFF, 8'h08, ChNul};
    play_format();
    fmt_q = '{8'h0E, ChNul};
    play_format();
    fmt_q = '{8'h61, ChNul, 8'h62, ChNul};
    play_format();

    // random strings, with calm stretches where neither side idles
    start = bytes_sent;
    while (bytes_sent - start < RandomBytes) begin
      calm = ($urandom_range(0, 4) == 0);
      build_random_format();
      play_format();
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("Covered %0d format strings in %0d bytes: %0d verdicts accepted, %0d rejected.",
             strings_sent, bytes_sent, strings_sent - rejected_seen, rejected_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
